@@ hw/rtl/imu_mc_pkg.sv @@
`timescale 1ns / 1ps

package imu_mc_pkg;

  // Configuration register indexes, in register-list order
  typedef enum logic [2:0] {
    REG_YAW   = 3'd0,
    REG_PITCH = 3'd1,
    REG_ROLL  = 3'd2,
    REG_SCL_X = 3'd3,
    REG_SCL_Y = 3'd4,
    REG_SCL_Z = 3'd5
  } cfg_reg_e;

  localparam int unsigned SINE_DEPTH_DEF = 1024;
  localparam int unsigned COEF_FRAC_DEF  = 16;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned SAMPLE_W   = 32;
  localparam logic [15:0] SCALE_RESET = 16'd16384;
  localparam int unsigned SCALE_FRAC = 14;

  // Scaled gyro product and the rounded scaled gyro
  localparam int unsigned GPROD_W = 48;
  localparam int unsigned GYRO_W  = 35;

  // Sine generation
  localparam int unsigned      WORK_BITS   = 30;
  localparam longint unsigned  HALF_PI_Q30 = 64'd1686629713;

  // Division by 36000 as a multiply by a reciprocal
  localparam int unsigned RECIP_W     = 31;
  localparam logic [30:0] RECIP_36000 = 31'd1954687339;
  localparam int unsigned RECIP_SHIFT = 46;

endpackage

@@ hw/rtl/imu_mounting_correction.sv @@
`timescale 1ns / 1ps

// Channel | dir | width         | contents
// s_axis  | in  | 192 tdata     | gyro x/y/z, accel x/y/z, signed Q16.16
// m_axis  | out | 192 tdata     | rate x/y/z, acc x/y/z, signed Q16.16
// cfg     | in  | 3 idx, 16 dat | yaw, pitch, roll, scale x/y/z
//
// One item per cycle while no rebuild runs and the output is not stalled; an item passes six register
// stages. After reset and each offset write a shared multiplier sequencer rebuilds the matrix; while
// the rebuild is pending or running, tready stays low and no item is accepted.
// Reset is asynchronous, active low; it resets control state and the config registers only.
// A stalled output freezes the whole pipeline in place; nothing is lost.
module imu_mounting_correction #(
  parameter int unsigned SINE_TABLE_DEPTH = imu_mc_pkg::SINE_DEPTH_DEF,
  parameter int unsigned COEF_FRAC_BITS   = imu_mc_pkg::COEF_FRAC_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z (lowest first)
  input  logic [6*imu_mc_pkg::SAMPLE_W-1:0]    s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // rate_out_x, rate_out_y, rate_out_z, acc_out_x, acc_out_y, acc_out_z
  output logic [6*imu_mc_pkg::SAMPLE_W-1:0]    m_axis_tdata_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [imu_mc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [imu_mc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import imu_mc_pkg::*;

  localparam int unsigned CW  = COEF_FRAC_BITS + 2;        // coefficient width
  localparam int unsigned IW  = $clog2(SINE_TABLE_DEPTH);  // table index width
  localparam int unsigned VW  = $clog2(68768 * SINE_TABLE_DEPTH + 18001);
  localparam int unsigned MW  = VW + RECIP_W;
  localparam int unsigned PW  = CW + GYRO_W;
  localparam int unsigned SW  = PW + 2;
  localparam int unsigned RW  = SW - COEF_FRAC_BITS + 1;
  localparam int unsigned SH  = WORK_BITS - COEF_FRAC_BITS;
  localparam longint unsigned ANG_BIAS = 64'd36000 * SINE_TABLE_DEPTH + 64'd18000;

  typedef logic [2*CW-1:0] rom_t [SINE_TABLE_DEPTH];

  // Sequencer codes
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_AMUL   = 3'd1;
  localparam logic [2:0] ST_AIDX   = 3'd2;
  localparam logic [2:0] ST_AROM   = 3'd3;
  localparam logic [2:0] ST_ASTORE = 3'd4;
  localparam logic [2:0] ST_QMUL   = 3'd5;
  localparam logic [2:0] ST_QRND   = 3'd6;
  localparam logic [2:0] ST_SUM    = 3'd7;
  localparam logic [3:0] OP_LAST   = 4'd13;

  function automatic logic [CW-1:0] q30_to_coef(longint s);
    longint t;
    t = (s < 0) ? 64'sd0 : s;
    t = (t + (64'sd1 <<< (SH - 1))) >>> SH;
    if (t > (64'sd1 <<< COEF_FRAC_BITS)) t = 64'sd1 <<< COEF_FRAC_BITS;
    return CW'(t);
  endfunction

  // Sine series term k: divide by (2k)(2k+1)
  function automatic longint unsigned sin_term(longint unsigned t, int k);
    case (k)
      1:       return t / 64'd6;
      2:       return t / 64'd20;
      3:       return t / 64'd42;
      4:       return t / 64'd72;
      5:       return t / 64'd110;
      6:       return t / 64'd156;
      7:       return t / 64'd210;
      default: return t / 64'd272;
    endcase
  endfunction

  // Cosine series term k: divide by (2k-1)(2k)
  function automatic longint unsigned cos_term(longint unsigned t, int k);
    case (k)
      1:       return t / 64'd2;
      2:       return t / 64'd12;
      3:       return t / 64'd30;
      4:       return t / 64'd56;
      5:       return t / 64'd90;
      6:       return t / 64'd132;
      7:       return t / 64'd182;
      default: return t / 64'd240;
    endcase
  endfunction

  // Full-turn table of {sin, cos}, built at elaboration
  function automatic rom_t build_rom();
    rom_t            r;
    longint unsigned four, quad, rem, x, x2, ts, tc;
    longint          ss, cc;
    logic [CW-1:0]   s, c;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      four = 64'(i) * 64'd4;
      quad = four / SINE_TABLE_DEPTH;
      rem  = four - quad * SINE_TABLE_DEPTH;
      x    = (HALF_PI_Q30 * rem) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> WORK_BITS;
      ts   = x;
      tc   = 64'd1 << WORK_BITS;
      ss   = longint'(x);
      cc   = longint'(tc);
      for (int k = 1; k <= 8; k++) begin
        ts = sin_term((ts * x2) >> WORK_BITS, k);
        tc = cos_term((tc * x2) >> WORK_BITS, k);
        if ((k & 1) == 1) begin
          ss = ss - longint'(ts);
          cc = cc - longint'(tc);
        end else begin
          ss = ss + longint'(ts);
          cc = cc + longint'(tc);
        end
      end
      s = q30_to_coef(ss);
      c = q30_to_coef(cc);
      case (quad[1:0])
        2'd0:    r[i] = {s, c};
        2'd1:    r[i] = {c, -s};
        2'd2:    r[i] = {-s, -c};
        default: r[i] = {-c, s};
      endcase
    end
    return r;
  endfunction

  localparam rom_t SINCOS_ROM = build_rom();

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] yaw_q, pitch_q, roll_q;
  logic [15:0] scl_q [3];
  logic        stale_q;
  logic        cfg_we;
  logic        ofs_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we = cfg_valid_i && cfg_ready_o;
  assign ofs_we = cfg_we && (cfg_index_i inside {REG_YAW, REG_PITCH, REG_ROLL});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_q   <= '0;
      pitch_q <= '0;
      roll_q  <= '0;
      scl_q[0] <= SCALE_RESET;
      scl_q[1] <= SCALE_RESET;
      scl_q[2] <= SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_YAW:   yaw_q    <= cfg_data_i;
        REG_PITCH: pitch_q  <= cfg_data_i;
        REG_ROLL:  roll_q   <= cfg_data_i;
        REG_SCL_X: scl_q[0] <= cfg_data_i;
        REG_SCL_Y: scl_q[1] <= cfg_data_i;
        REG_SCL_Z: scl_q[2] <= cfg_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Matrix rebuild sequencer
  // ---------------------------------------------------------------------------
  logic [2:0]           state_q;
  logic [1:0]           ang_q;
  logic [3:0]           op_q;
  logic [MW-1:0]        aprod_q;
  logic [IW-1:0]        idx_q;
  logic [2*CW-1:0]      rom_q;
  logic signed [CW-1:0] sc_q [6];   // sy, cy, sp, cp, sr, cr
  logic signed [2*CW-1:0] qprod_q;
  logic signed [CW-1:0] qv_q [14];
  logic signed [CW-1:0] m_q [9];

  logic [15:0]          ang_sel;
  logic signed [VW:0]   ang_ext, v_s;
  logic [MW-1:0]        aprod_d;
  logic [IW:0]          n_raw;
  logic [IW-1:0]        idx_d;
  logic signed [CW-1:0] opa, opb;
  logic signed [2*CW-1:0] qa, qb, qmag, qrnd;
  logic signed [CW:0]   msum [9];

  logic signed [CW-1:0] sy, cy, sp, cp, sr, cr;
  assign sy = sc_q[0];
  assign cy = sc_q[1];
  assign sp = sc_q[2];
  assign cp = sc_q[3];
  assign sr = sc_q[4];
  assign cr = sc_q[5];

  // Angle to table entry: floor((a*D + 36000*D + 18000) / 36000) mod D
  always_comb begin
    case (ang_q)
      2'd0:    ang_sel = yaw_q;
      2'd1:    ang_sel = pitch_q;
      default: ang_sel = roll_q;
    endcase
    ang_ext = (VW + 1)'($signed(ang_sel));
    v_s     = ang_ext * $signed((VW + 1)'(SINE_TABLE_DEPTH)) + $signed((VW + 1)'(ANG_BIAS));
    aprod_d = MW'(v_s[VW-1:0]) * MW'(RECIP_36000);
    n_raw   = aprod_q[RECIP_SHIFT +: IW + 1];
    if (n_raw >= (IW + 1)'(SINE_TABLE_DEPTH)) begin
      idx_d = IW'(n_raw - (IW + 1)'(SINE_TABLE_DEPTH));
    end else begin
      idx_d = n_raw[IW-1:0];
    end
  end

  // Operand schedule of the coefficient products
  always_comb begin
    case (op_q)
      4'd0:    begin opa = cy;       opb = cr; end
      4'd1:    begin opa = sy;       opb = sp; end
      4'd2:    begin opa = qv_q[1];  opb = sr; end
      4'd3:    begin opa = cp;       opb = sy; end
      4'd4:    begin opa = cy;       opb = sr; end
      4'd5:    begin opa = cr;       opb = sy; end
      4'd6:    begin opa = qv_q[5];  opb = sp; end
      4'd7:    begin opa = cy;       opb = sp; end
      4'd8:    begin opa = qv_q[7];  opb = sr; end
      4'd9:    begin opa = cy;       opb = cp; end
      4'd10:   begin opa = sy;       opb = sr; end
      4'd11:   begin opa = qv_q[0];  opb = sp; end
      4'd12:   begin opa = cp;       opb = sr; end
      default: begin opa = cp;       opb = cr; end
    endcase
    qa   = (2 * CW)'(opa);
    qb   = (2 * CW)'(opb);
    // round half away from zero
    qmag = qprod_q[2*CW-1] ? -qprod_q : qprod_q;
    qrnd = (qmag + ((2 * CW)'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    if (qprod_q[2*CW-1]) qrnd = -qrnd;
  end

  // Final combination of the products into the nine coefficients
  always_comb begin
    msum[0] = (CW + 1)'(qv_q[0]) + (CW + 1)'(qv_q[2]);
    msum[1] = (CW + 1)'(qv_q[3]);
    msum[2] = (CW + 1)'(qv_q[4]) - (CW + 1)'(qv_q[6]);
    msum[3] = (CW + 1)'(qv_q[8]) - (CW + 1)'(qv_q[5]);
    msum[4] = (CW + 1)'(qv_q[9]);
    msum[5] = -(CW + 1)'(qv_q[10]) - (CW + 1)'(qv_q[11]);
    msum[6] = -(CW + 1)'(qv_q[12]);
    msum[7] = (CW + 1)'(sp);
    msum[8] = (CW + 1)'(qv_q[13]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stale_q <= 1'b1;
      ang_q   <= '0;
      op_q    <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (stale_q) begin
            state_q <= ST_AMUL;
            ang_q   <= '0;
          end
        end
        ST_AMUL:  state_q <= ST_AIDX;
        ST_AIDX:  state_q <= ST_AROM;
        ST_AROM:  state_q <= ST_ASTORE;
        ST_ASTORE: begin
          if (ang_q == 2'd2) begin
            state_q <= ST_QMUL;
            op_q    <= '0;
          end else begin
            ang_q   <= ang_q + 2'd1;
            state_q <= ST_AMUL;
          end
        end
        ST_QMUL:  state_q <= ST_QRND;
        ST_QRND: begin
          if (op_q == OP_LAST) begin
            state_q <= ST_SUM;
          end else begin
            op_q    <= op_q + 4'd1;
            state_q <= ST_QMUL;
          end
        end
        ST_SUM:   state_q <= ST_IDLE;
        default:  state_q <= ST_IDLE;
      endcase
      // a new offset write keeps the rebuild pending
      if (ofs_we) begin
        stale_q <= 1'b1;
      end else if (state_q == ST_IDLE && stale_q) begin
        stale_q <= 1'b0;
      end
    end
  end

  // Sequencer data path; the table is read through a registered port
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_AMUL:   aprod_q <= aprod_d;
      ST_AIDX:   idx_q   <= idx_d;
      ST_AROM:   rom_q   <= SINCOS_ROM[idx_q];
      ST_ASTORE: begin
        sc_q[{ang_q, 1'b0}] <= rom_q[2*CW-1:CW];
        sc_q[{ang_q, 1'b1}] <= rom_q[CW-1:0];
      end
      ST_QMUL:   qprod_q <= qa * qb;
      ST_QRND:   qv_q[op_q] <= qrnd[CW-1:0];
      ST_SUM: begin
        for (int i = 0; i < 9; i++) begin
          if (msum[i] > (CW + 1)'((1 <<< (CW - 1)) - 1)) begin
            m_q[i] <= {1'b0, {(CW - 1){1'b1}}};
          end else if (msum[i] < -((CW + 1)'(1) <<< (CW - 1))) begin
            m_q[i] <= {1'b1, {(CW - 1){1'b0}}};
          end else begin
            m_q[i] <= msum[i][CW-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sample pipeline: scale, round, matrix products, row sums, round, saturate
  // ---------------------------------------------------------------------------
  logic adv;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, ov_q;
  logic signed [GPROD_W-1:0]  gp_q [3];
  logic signed [SAMPLE_W-1:0] ac1_q [3], ac2_q [3];
  logic signed [GYRO_W-1:0]   g2_q [3];
  logic signed [PW-1:0]       pg_q [9], pa_q [9];
  logic signed [SW-1:0]       sg_q [3], sa_q [3];
  logic signed [RW-1:0]       rg_q [3], ra_q [3];
  logic [SAMPLE_W-1:0]        out_q [6];

  logic signed [GPROD_W-1:0]  gp_d [3];
  logic signed [GYRO_W-1:0]   g2_d [3];
  logic signed [PW-1:0]       pg_d [9], pa_d [9];
  logic signed [SW-1:0]       sg_d [3], sa_d [3];
  logic signed [RW-1:0]       rg_d [3], ra_d [3];
  logic [SAMPLE_W-1:0]        out_d [6];
  logic                       in_acc;

  // the whole pipe moves when the output register is free or being emptied
  assign adv             = !ov_q || m_axis_tready_i;
  assign s_axis_tready_o = adv && (state_q == ST_IDLE) && !stale_q;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  function automatic logic [SAMPLE_W-1:0] sat32(logic signed [RW-1:0] v);
    if (v > RW'((64'sd1 <<< (SAMPLE_W - 1)) - 1)) return {1'b0, {(SAMPLE_W - 1){1'b1}}};
    if (v < -(RW'(1) <<< (SAMPLE_W - 1)))           return {1'b1, {(SAMPLE_W - 1){1'b0}}};
    return v[SAMPLE_W-1:0];
  endfunction

  always_comb begin
    logic signed [GPROD_W-1:0] ge, se, gmag, grnd;
    logic signed [PW-1:0]      ma, ge2, ae2;
    logic signed [SW:0]        smag, srnd;
    for (int i = 0; i < 3; i++) begin
      ge      = GPROD_W'($signed(s_axis_tdata_i[i*SAMPLE_W +: SAMPLE_W]));
      se      = GPROD_W'({1'b0, scl_q[i]});
      gp_d[i] = ge * se;
      gmag    = gp_q[i][GPROD_W-1] ? -gp_q[i] : gp_q[i];
      grnd    = (gmag + (GPROD_W'(1) <<< (SCALE_FRAC - 1))) >>> SCALE_FRAC;
      if (gp_q[i][GPROD_W-1]) grnd = -grnd;
      g2_d[i] = grnd[GYRO_W-1:0];
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        ma  = PW'(m_q[r*3+c]);
        ge2 = PW'(g2_q[c]);
        ae2 = PW'(ac2_q[c]);
        pg_d[r*3+c] = ma * ge2;
        pa_d[r*3+c] = ma * ae2;
      end
      sg_d[r] = SW'(pg_q[r*3]) + SW'(pg_q[r*3+1]) + SW'(pg_q[r*3+2]);
      sa_d[r] = SW'(pa_q[r*3]) + SW'(pa_q[r*3+1]) + SW'(pa_q[r*3+2]);

      smag = sg_q[r][SW-1] ? -(SW + 1)'(sg_q[r]) : (SW + 1)'(sg_q[r]);
      srnd = (smag + ((SW + 1)'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
      if (sg_q[r][SW-1]) srnd = -srnd;
      rg_d[r] = srnd[RW-1:0];

      smag = sa_q[r][SW-1] ? -(SW + 1)'(sa_q[r]) : (SW + 1)'(sa_q[r]);
      srnd = (smag + ((SW + 1)'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
      if (sa_q[r][SW-1]) srnd = -srnd;
      ra_d[r] = srnd[RW-1:0];

      out_d[r]     = sat32(rg_q[r]);
      out_d[3 + r] = sat32(ra_q[r]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_acc;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      ov_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        gp_q[i]  <= gp_d[i];
        ac1_q[i] <= $signed(s_axis_tdata_i[(3 + i)*SAMPLE_W +: SAMPLE_W]);
        g2_q[i]  <= g2_d[i];
        ac2_q[i] <= ac1_q[i];
        sg_q[i]  <= sg_d[i];
        sa_q[i]  <= sa_d[i];
        rg_q[i]  <= rg_d[i];
        ra_q[i]  <= ra_d[i];
      end
      for (int i = 0; i < 9; i++) begin
        pg_q[i] <= pg_d[i];
        pa_q[i] <= pa_d[i];
      end
      for (int i = 0; i < 6; i++) begin
        out_q[i] <= out_d[i];
      end
    end
  end

  assign m_axis_tvalid_o = ov_q;
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      m_axis_tdata_o[i*SAMPLE_W +: SAMPLE_W] = out_q[i];
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_take_after_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ofs_we |=> !s_axis_tready_o)
    else $error("item accepted right after an offset write");

  a_no_item_in_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !v1_q || !$past(in_acc))
    else $error("item entered during matrix rebuild");

  a_sum_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |=> (state_q == ST_IDLE))
    else $error("rebuild did not return to idle");

  a_op_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_q <= OP_LAST)
    else $error("product schedule ran past its end");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable({v1_q, v2_q, v3_q, v4_q, v5_q}))
    else $error("pipeline valids moved while stalled");

endmodule
